>>> rtl/acl_pkg.sv
// acl_pkg: shared types and constants for the ARP cache learner.
// Used by acl_scan and arp_cache_learner_unit; no dependencies.
package acl_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF = 8;
  localparam int unsigned IDX_W             = 6;   // entry index port width, up to 64 entries
  localparam int unsigned IP_W              = 32;
  localparam int unsigned MAC_W             = 48;
  localparam int unsigned VPTR_W            = 8;

  localparam logic [15:0] ETYPE_IP    = 16'h0800;
  localparam logic [15:0] ETYPE_ARP   = 16'h0806;
  localparam logic [10:0] MIN_IP_LEN  = 11'd34;
  localparam logic [10:0] MIN_ARP_LEN = 11'd42;
  localparam logic [15:0] OP_REQUEST  = 16'd1;
  localparam logic [15:0] OP_REPLY    = 16'd2;

  typedef enum logic [1:0] {
    OUT_IGNORED  = 2'd0,
    OUT_REFRESH  = 2'd1,
    OUT_ADDED    = 2'd2,
    OUT_REPLACED = 2'd3
  } outcome_t;

  // Scan result handed from the scan unit to the control FSM
  typedef struct packed {
    logic                   valid;
    outcome_t               code;
    logic [IDX_W-1:0]       idx;
  } scan_done_t;

endpackage

>>> rtl/acl_ram.sv
// acl_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module acl_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> rtl/acl_scan.sv
// acl_scan: walks the cache one entry per cycle through the shared IP comparator,
// finds a hit or the first free entry and picks the target. Depends on acl_pkg.
module acl_scan #(
  parameter int unsigned CACHE_ENTRIES = acl_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [acl_pkg::IP_W-1:0]     key_ip,
  input  logic [CACHE_ENTRIES-1:0]     written,
  input  logic [acl_pkg::IDX_W-1:0]    victim_idx,
  output logic                         rd_en,
  output logic [acl_pkg::IDX_W-1:0]    rd_addr,
  input  logic [acl_pkg::IP_W-1:0]     rd_ip,
  output acl_pkg::scan_done_t          done
);

  import acl_pkg::*;

  localparam int unsigned IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(CACHE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);

  logic          busy_r,       busy_nxt;
  logic [CW-1:0] cnt_r,        cnt_nxt;
  logic          rvalid_r,     rvalid_nxt;
  logic [IW-1:0] cmp_idx_r,    cmp_idx_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r,   free_idx_nxt;

  logic issue;
  logic hit;
  logic is_free;
  logic finish;

  assign issue   = busy_r && (cnt_r < CNT_END);
  assign rd_en   = issue;
  assign rd_addr = IDX_W'(cnt_r[IW-1:0]);

  // Compare stage: RAM data belongs to cmp_idx_r
  assign hit     = rvalid_r && written[cmp_idx_r] && (rd_ip == key_ip);
  assign is_free = rvalid_r && !written[cmp_idx_r];
  assign finish  = hit || (rvalid_r && (cmp_idx_r == LAST_IDX));

  always_comb begin
    done.valid = finish;
    if (hit) begin
      done.code = OUT_REFRESH;
      done.idx  = IDX_W'(cmp_idx_r);
    end else if (free_found_r) begin
      done.code = OUT_ADDED;
      done.idx  = IDX_W'(free_idx_r);
    end else if (is_free) begin
      done.code = OUT_ADDED;
      done.idx  = IDX_W'(cmp_idx_r);
    end else begin
      done.code = OUT_REPLACED;
      done.idx  = victim_idx;
    end
  end

  always_comb begin
    busy_nxt       = busy_r;
    cnt_nxt        = cnt_r;
    rvalid_nxt     = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    if (start) begin
      busy_nxt       = 1'b1;
      cnt_nxt        = '0;
      free_found_nxt = 1'b0;
    end else if (busy_r) begin
      if (finish) begin
        busy_nxt = 1'b0;
      end else begin
        rvalid_nxt  = issue;
        cmp_idx_nxt = cnt_r[IW-1:0];
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        // remember the lowest free entry seen
        if (is_free && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = cmp_idx_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      cnt_r        <= '0;
      rvalid_r     <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      cnt_r        <= cnt_nxt;
      rvalid_r     <= rvalid_nxt;
      free_found_r <= free_found_nxt;
    end
    cmp_idx_r  <= cmp_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

endmodule

>>> rtl/arp_cache_learner_unit.sv
// Flow: an ignored word goes from the idle state to the commit state; a learned word first
// scans entries through one comparator, stopping early on a hit, then commits its result.
// Input stalls outside the idle state, so a new word is taken only after the last one commits;
// the scan pace is set by the single RAM read port feeding the shared IP comparator.
// Reset (rst_n, synchronous): cache entries read as free, counters, victim pointer and
// the local IP register clear; the RAM itself holds no reset and needs no clearing pass.
module arp_cache_learner_unit #(
  parameter int unsigned CACHE_ENTRIES = acl_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [acl_pkg::IP_W-1:0]      cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [15:0]                   in_ether_type,
  input  logic [10:0]                   in_frame_length,
  input  logic [acl_pkg::MAC_W-1:0]     in_sender_mac,
  input  logic [acl_pkg::IP_W-1:0]      in_sender_ip,
  input  logic [15:0]                   in_arp_operation,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_outcome,
  output logic [acl_pkg::IDX_W-1:0]     out_entry_index,
  output logic [31:0]                   out_additions_total,
  output logic [31:0]                   out_requests_total,
  output logic [31:0]                   out_replies_total
);

  import acl_pkg::*;

  localparam int unsigned IW    = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned WORD_W = MAC_W + IP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t                   state_r;
  logic [IP_W-1:0]          own_ip_r;
  logic [IP_W-1:0]          ip_r;
  logic [MAC_W-1:0]         mac_r;
  logic                     req_r;
  logic                     rep_r;
  outcome_t                 dec_code_r;
  logic [IDX_W-1:0]         dec_idx_r;
  logic [CACHE_ENTRIES-1:0] written_r;
  logic [VPTR_W-1:0]        vptr_r;
  logic [IW-1:0]            vmod_r;
  logic [31:0]              additions_r;
  logic [31:0]              requests_r;
  logic [31:0]              replies_r;
  logic                     out_valid_r;
  outcome_t                 out_outcome_r;
  logic [IDX_W-1:0]         out_index_r;

  logic               in_acc;
  logic               ip_ok;
  logic               arp_ok;
  logic               learn_ok;
  logic               slot_free;
  logic               commit_fire;
  logic               do_write;
  logic [IW-1:0]      vmod_nxt;
  logic               ram_re;
  logic [IDX_W-1:0]   scan_rd_addr;
  logic [WORD_W-1:0]  ram_rdata;
  scan_done_t         scan_done;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  assign ip_ok    = (in_ether_type == ETYPE_IP) && (in_frame_length >= MIN_IP_LEN);
  assign arp_ok   = (in_ether_type == ETYPE_ARP) && (in_frame_length >= MIN_ARP_LEN);
  assign learn_ok = (ip_ok || arp_ok) && (in_sender_ip != '0) && (in_sender_ip != own_ip_r);

  assign slot_free   = !out_valid_r || !out_stall;
  assign commit_fire = (state_r == ST_COMMIT) && slot_free;
  assign do_write    = commit_fire && (dec_code_r != OUT_IGNORED);

  // pointer modulo entry count, tracked alongside the 8-bit pointer
  assign vmod_nxt = ((vptr_r == '1) || (vmod_r == LAST_IDX)) ? '0 : vmod_r + 1'b1;

  acl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (dec_idx_r[IW-1:0]),
    .wdata ({mac_r, ip_r}),
    .re    (ram_re),
    .raddr (scan_rd_addr[IW-1:0]),
    .rdata (ram_rdata)
  );

  acl_scan #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc && learn_ok),
    .key_ip     (ip_r),
    .written    (written_r),
    .victim_idx (IDX_W'(vmod_r)),
    .rd_en      (ram_re),
    .rd_addr    (scan_rd_addr),
    .rd_ip      (ram_rdata[IP_W-1:0]),
    .done       (scan_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      own_ip_r      <= '0;
      written_r     <= '0;
      vptr_r        <= '0;
      vmod_r        <= '0;
      additions_r   <= '0;
      requests_r    <= '0;
      replies_r     <= '0;
      out_valid_r   <= 1'b0;
      out_outcome_r <= OUT_IGNORED;
      out_index_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        own_ip_r <= cfg_wr_data;
      end
      if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            ip_r       <= in_sender_ip;
            mac_r      <= in_sender_mac;
            req_r      <= arp_ok && (in_arp_operation == OP_REQUEST);
            rep_r      <= arp_ok && (in_arp_operation == OP_REPLY);
            dec_code_r <= OUT_IGNORED;
            dec_idx_r  <= '0;
            state_r    <= learn_ok ? ST_SCAN : ST_COMMIT;
          end
        end
        ST_SCAN: begin
          if (scan_done.valid) begin
            dec_code_r <= scan_done.code;
            dec_idx_r  <= scan_done.idx;
            state_r    <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          // hold until the output register is free
          if (commit_fire) begin
            if (do_write) begin
              written_r[dec_idx_r[IW-1:0]] <= 1'b1;
            end
            if (dec_code_r == OUT_ADDED || dec_code_r == OUT_REPLACED) begin
              additions_r <= additions_r + 32'd1;
            end
            if (dec_code_r == OUT_REPLACED) begin
              vptr_r <= vptr_r + 1'b1;
              vmod_r <= vmod_nxt;
            end
            if (req_r) begin
              requests_r <= requests_r + 32'd1;
            end
            if (rep_r) begin
              replies_r <= replies_r + 32'd1;
            end
            out_outcome_r <= dec_code_r;
            out_index_r   <= dec_idx_r;
            out_valid_r   <= 1'b1;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_outcome         = out_outcome_r;
  assign out_entry_index     = out_index_r;
  assign out_additions_total = additions_r;
  assign out_requests_total  = requests_r;
  assign out_replies_total   = replies_r;

  // an entry once learned never returns to free
  a_written_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((written_r & $past(written_r)) == $past(written_r)))
    else $error("cache entry lost its written mark");

  // the addition count moves only on a commit that adds or replaces
  a_add_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (additions_r != $past(additions_r))) |->
      ($past(commit_fire) &&
       ($past(dec_code_r) == OUT_ADDED || $past(dec_code_r) == OUT_REPLACED)))
    else $error("addition count changed without an addition");

  // the victim pointer advances only on a replacement
  a_victim_on_replace: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (vptr_r != $past(vptr_r))) |->
      ($past(commit_fire) && $past(dec_code_r) == OUT_REPLACED))
    else $error("victim pointer moved without a replacement");

  // an ignored result always reports entry zero
  a_ignored_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_outcome_r == OUT_IGNORED) |-> (out_index_r == '0))
    else $error("ignored result carries a nonzero entry index");

  // the scan unit reports completion only while the FSM waits on it
  a_scan_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done.valid |-> (state_r == ST_SCAN))
    else $error("scan completed outside the scan state");

endmodule
